FILE: rtl/uart_pkg.sv
// ----------------------------------------------------------------------------
// uart_pkg: shared types and constants for the UART transceiver
// Field widths, register reset values, register indexes and the structs that
// run between the transceiver's submodules.
// ----------------------------------------------------------------------------
package uart_pkg;

	localparam int CPB_W         = 16;
	localparam int DBITS_W       = 4;
	localparam int BYTE_W        = 8;
	localparam int TX_FIFO_DEPTH = 16;

	localparam logic [CPB_W-1:0]   CPB_RESET   = 16'd868;
	localparam logic [DBITS_W-1:0] DBITS_RESET = 4'd8;

	// register indexes on the configuration port
	localparam logic CFG_CLOCKS_PER_BIT = 1'b0;
	localparam logic CFG_DATA_BITS      = 1'b1;

	// live configuration, seen by both serial engines
	typedef struct packed {
		logic [CPB_W-1:0]   clocks_per_bit;
		logic [DBITS_W-1:0] data_bits;
	} cfg_t;

	// head of the transmit queue as offered to the transmitter
	typedef struct packed {
		logic              avail;
		logic [BYTE_W-1:0] data;
	} fifo_head_t;

endpackage

FILE: rtl/uart_ram.sv
// ----------------------------------------------------------------------------
// uart_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module uart_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/uart_fifo.sv
// ----------------------------------------------------------------------------
// uart_fifo: transmit byte queue
// Pointers and occupancy around a synchronous RAM. The RAM is read every
// cycle at the next read pointer, with a bypass for a write to that entry.
// ----------------------------------------------------------------------------
module uart_fifo #(
	parameter int DEPTH = uart_pkg::TX_FIFO_DEPTH,
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          step,
	input  logic                          pop,
	input  logic                          push,
	input  logic [uart_pkg::BYTE_W-1:0]   push_byte,
	output uart_pkg::fifo_head_t          head,
	output logic                          dropped,
	output logic [CNT_W-1:0]              count_next
);

	logic [PTR_W-1:0]            rd_ptr_q, wr_ptr_q, rd_ptr_next, wr_ptr_inc;
	logic [CNT_W-1:0]            count_q;
	logic                        push_ok, full;
	logic                        fwd_q;
	logic [uart_pkg::BYTE_W-1:0] fwd_data_q, rdata;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	// push/pop decisions for this transaction; a pop frees a slot for the push
	assign full        = (count_q >= CNT_W'(DEPTH)) && !pop;
	assign push_ok     = step && push && !full;
	assign dropped     = push && full;
	assign wr_ptr_inc  = ptr_inc(wr_ptr_q);
	assign rd_ptr_next = (step && pop) ? ptr_inc(rd_ptr_q) : rd_ptr_q;
	assign count_next  = count_q - CNT_W'(pop) + CNT_W'(push && !full);

	uart_ram #(
		.WIDTH (uart_pkg::BYTE_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (push_ok),
		.waddr (wr_ptr_q),
		.wdata (push_byte),
		.raddr (rd_ptr_next),
		.rdata (rdata)
	);

	// pointers, occupancy and write-to-read bypass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
			fwd_q    <= 1'b0;
		end else begin
			fwd_q <= push_ok && (wr_ptr_q == rd_ptr_next);
			if (step) begin
				rd_ptr_q <= rd_ptr_next;
				count_q  <= count_next;
				if (push_ok) begin
					wr_ptr_q <= wr_ptr_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_data_q <= push_byte;
	end

	assign head.avail = (count_q != '0);
	assign head.data  = fwd_q ? fwd_data_q : rdata;

endmodule

FILE: rtl/uart_rx.sv
// ----------------------------------------------------------------------------
// uart_rx: serial receiver
// Start detect, one start period, mid-period sampling of up to eight data
// bits LSB first, and an unchecked stop period. Advances once per transaction.
// ----------------------------------------------------------------------------
module uart_rx (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        step,
	input  logic                        line,
	input  uart_pkg::cfg_t              cfg,
	output logic                        done,
	output logic [uart_pkg::BYTE_W-1:0] byte_out
);

	typedef enum logic [1:0] {
		RX_IDLE,
		RX_SBIT,
		RX_DATA,
		RX_STOP
	} rx_state_t;

	rx_state_t                        state_q, state_d;
	logic [uart_pkg::CPB_W-1:0]       cnt_q, cnt_d, cnt_inc;
	logic [uart_pkg::DBITS_W-1:0]     idx_q, idx_d;
	logic [uart_pkg::BYTE_W-1:0]      shift_q, shift_d, shift_smp;

	assign cnt_inc = cnt_q + uart_pkg::CPB_W'(1);

	// next-state logic for one tick
	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		shift_d   = shift_q;
		shift_smp = shift_q;
		done      = 1'b0;
		byte_out  = '0;
		unique case (state_q)
			RX_IDLE: begin
				if (!line) begin
					state_d = RX_SBIT;
					shift_d = '0;
					cnt_d   = '0;
					idx_d   = '0;
				end
			end
			RX_SBIT: begin
				cnt_d = cnt_inc;
				idx_d = '0;
				if (cnt_inc >= cfg.clocks_per_bit) begin
					cnt_d   = '0;
					state_d = RX_DATA;
				end
			end
			RX_DATA: begin
				// sample at mid-period; bits past the eighth are discarded
				if (cnt_inc == (cfg.clocks_per_bit >> 1) && !idx_q[3]) begin
					shift_smp = shift_q | (uart_pkg::BYTE_W'(line) << idx_q[2:0]);
				end
				shift_d = shift_smp;
				cnt_d   = cnt_inc;
				if (cnt_inc >= cfg.clocks_per_bit) begin
					cnt_d = '0;
					idx_d = idx_q + uart_pkg::DBITS_W'(1);
				end
				if (idx_d >= cfg.data_bits) begin
					state_d  = RX_STOP;
					cnt_d    = '0;
					done     = 1'b1;
					byte_out = shift_smp;
					shift_d  = '0;
				end
			end
			RX_STOP: begin
				cnt_d = cnt_inc;
				if (cnt_inc == cfg.clocks_per_bit) begin
					cnt_d   = '0;
					state_d = RX_IDLE;
				end
			end
			default: state_d = RX_IDLE;
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RX_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
			shift_q <= '0;
		end else if (step) begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			shift_q <= shift_d;
		end
	end

endmodule

FILE: rtl/uart_tx.sv
// ----------------------------------------------------------------------------
// uart_tx: serial transmitter
// Pops a byte from the queue when idle, then drives start, data bits LSB
// first and one stop bit. Advances once per transaction.
// ----------------------------------------------------------------------------
module uart_tx (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  uart_pkg::cfg_t       cfg,
	input  uart_pkg::fifo_head_t head,
	output logic                 pop,
	output logic                 level
);

	typedef enum logic [1:0] {
		TX_IDLE,
		TX_SBIT,
		TX_DATA,
		TX_STOP
	} tx_state_t;

	tx_state_t                    state_q, state_d;
	logic [uart_pkg::CPB_W-1:0]   cnt_q, cnt_d, cnt_inc;
	logic [uart_pkg::DBITS_W-1:0] idx_q, idx_d;
	logic [uart_pkg::BYTE_W-1:0]  shift_q, shift_d;

	assign cnt_inc = cnt_q + uart_pkg::CPB_W'(1);

	// next-state logic and line level for one tick
	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		idx_d   = idx_q;
		shift_d = shift_q;
		pop     = 1'b0;
		level   = 1'b1;
		unique case (state_q)
			TX_IDLE: begin
				if (head.avail) begin
					pop     = 1'b1;
					shift_d = head.data;
					state_d = TX_SBIT;
					cnt_d   = '0;
					idx_d   = '0;
				end
			end
			TX_SBIT: begin
				level = 1'b0;
				cnt_d = cnt_inc;
				if (cnt_inc >= cfg.clocks_per_bit) begin
					idx_d   = '0;
					cnt_d   = '0;
					state_d = TX_DATA;
				end
			end
			TX_DATA: begin
				level = shift_q[0];
				cnt_d = cnt_inc;
				if (cnt_inc >= cfg.clocks_per_bit) begin
					cnt_d   = '0;
					idx_d   = idx_q + uart_pkg::DBITS_W'(1);
					shift_d = shift_q >> 1;
				end
				if (idx_d >= cfg.data_bits) begin
					state_d = TX_STOP;
					cnt_d   = '0;
				end
			end
			TX_STOP: begin
				cnt_d = cnt_inc;
				if (cnt_inc == cfg.clocks_per_bit) begin
					cnt_d   = '0;
					state_d = TX_IDLE;
				end
			end
			default: state_d = TX_IDLE;
		endcase
	end

	// state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= TX_IDLE;
			cnt_q   <= '0;
			idx_q   <= '0;
			shift_q <= '0;
		end else if (step) begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			idx_q   <= idx_d;
			shift_q <= shift_d;
		end
	end

endmodule

FILE: rtl/uart_transceiver.sv
// A result lands in the output register in the cycle after its input
//   transaction is accepted; throughput is one transaction per cycle while
//   the output register is empty or its old result is being taken.
// The transmit queue RAM is read every cycle with a registered read and a
//   write bypass, so a pop never stalls. Reset clears control state, sets
//   clocks_per_bit 868 and data_bits 8, and leaves queue contents as they are.
// ----------------------------------------------------------------------------
// uart_transceiver: UART transceiver with transmit queue
// Each transaction is one serial tick: a receive level and an optional byte
// to queue. Each yields one result with the transmit level and any received
// character.
// ----------------------------------------------------------------------------
module uart_transceiver #(
	parameter int TX_FIFO_DEPTH = uart_pkg::TX_FIFO_DEPTH,
	localparam int CNT_W = $clog2(TX_FIFO_DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [uart_pkg::CPB_W-1:0]    cfg_wdata,
	// input channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          rx_line,
	input  logic                          tx_push_valid,
	input  logic [uart_pkg::BYTE_W-1:0]   tx_push_byte,
	// output channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          tx_line,
	output logic                          rx_byte_valid,
	output logic [uart_pkg::BYTE_W-1:0]   rx_byte,
	output logic                          tx_push_dropped,
	output logic [CNT_W-1:0]              tx_queue_level
);

	uart_pkg::cfg_t              cfg_q;
	uart_pkg::fifo_head_t        head;
	logic                        step, pop, level, rx_done, dropped;
	logic [uart_pkg::BYTE_W-1:0] rx_data;
	logic [CNT_W-1:0]            count_next;

	assign in_ready = !out_valid || out_ready;
	assign step     = in_valid && in_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clocks_per_bit <= uart_pkg::CPB_RESET;
			cfg_q.data_bits      <= uart_pkg::DBITS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				uart_pkg::CFG_CLOCKS_PER_BIT: cfg_q.clocks_per_bit <= cfg_wdata;
				uart_pkg::CFG_DATA_BITS:
					cfg_q.data_bits <= cfg_wdata[uart_pkg::DBITS_W-1:0];
				default: ;
			endcase
		end
	end

	uart_rx u_rx (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (step),
		.line     (rx_line),
		.cfg      (cfg_q),
		.done     (rx_done),
		.byte_out (rx_data)
	);

	uart_tx u_tx (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cfg    (cfg_q),
		.head   (head),
		.pop    (pop),
		.level  (level)
	);

	uart_fifo #(
		.DEPTH (TX_FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.pop        (pop),
		.push       (tx_push_valid),
		.push_byte  (tx_push_byte),
		.head       (head),
		.dropped    (dropped),
		.count_next (count_next)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			tx_line         <= level;
			rx_byte_valid   <= rx_done;
			rx_byte         <= rx_data;
			tx_push_dropped <= dropped;
			tx_queue_level  <= count_next;
		end
	end

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for the UART transceiver
// Every transaction is one serial tick. A tick-level predictor follows the
// receive and transmit engines and the transmit queue. Each result is checked
// field by field against the oldest prediction. Stimulus is a short table at
// the reset settings, then phases of UART frames mixed with noise at several
// bit periods and character sizes. The sender works in bursts and the
// receiver stalls in patterns.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LVL_W      = $clog2(uart_pkg::TX_FIFO_DEPTH + 1);
	localparam int HOLD_TICKS = 80;
	localparam int MAX_PLAN_W = 64;

	typedef enum logic [1:0] {SER_IDLE, SER_START, SER_DATA, SER_STOP} ser_phase_t;

	typedef struct packed {
		logic                        tx_line;
		logic                        rx_valid;
		logic [uart_pkg::BYTE_W-1:0] rx_data;
		logic                        dropped;
		logic [LVL_W-1:0]            level;
	} tick_result_t;

	typedef struct {
		logic                        line;
		logic                        push;
		logic [uart_pkg::BYTE_W-1:0] data;
		logic                        typed;
		tick_result_t                res;
	} table_row_t;

	logic                          clk = 1'b0;
	logic                          arst_n;
	logic                          cfg_we;
	logic                          cfg_index;
	logic [uart_pkg::CPB_W-1:0]    cfg_wdata;
	logic                          in_valid;
	logic                          in_ready;
	logic                          rx_line;
	logic                          tx_push_valid;
	logic [uart_pkg::BYTE_W-1:0]   tx_push_byte;
	logic                          out_valid;
	logic                          out_ready;
	logic                          tx_line;
	logic                          rx_byte_valid;
	logic [uart_pkg::BYTE_W-1:0]   rx_byte;
	logic                          tx_push_dropped;
	logic [LVL_W-1:0]              tx_queue_level;

	// typed expectation travels with the transaction, sampled at acceptance
	logic                row_typed;
	tick_result_t        row_res;

	uart_transceiver dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.rx_line         (rx_line),
		.tx_push_valid   (tx_push_valid),
		.tx_push_byte    (tx_push_byte),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.tx_line         (tx_line),
		.rx_byte_valid   (rx_byte_valid),
		.rx_byte         (rx_byte),
		.tx_push_dropped (tx_push_dropped),
		.tx_queue_level  (tx_queue_level)
	);

	always #2 clk = ~clk;

	// predictor state
	logic [uart_pkg::CPB_W-1:0]    p_cpb;
	logic [uart_pkg::DBITS_W-1:0]  p_dbits;
	ser_phase_t                    rx_phase, tx_phase;
	logic [15:0]                   rx_ticks, tx_ticks;
	logic [3:0]                    rx_bit, tx_bit;
	logic [uart_pkg::BYTE_W-1:0]   rx_shreg, tx_shreg;
	logic [uart_pkg::BYTE_W-1:0]   txq_mem [uart_pkg::TX_FIFO_DEPTH];
	int unsigned                   txq_rd, txq_wr, txq_count;

	tick_result_t        pending_results [$];
	int                  errors = 0;
	bit                  hold_req = 0;

	// stimulus state
	bit                  rx_plan [$];
	int                  plan_w = 1;
	int                  plan_bits = 8;
	int                  burst_left = 0;
	table_row_t          dir_rows [$];

	task automatic report_mismatch(input string msg);
		$display("MISMATCH: %s", msg);
		errors++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
		input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	task automatic reset_predictor();
		p_cpb     = uart_pkg::CPB_RESET;
		p_dbits   = uart_pkg::DBITS_RESET;
		rx_phase  = SER_IDLE;
		tx_phase  = SER_IDLE;
		rx_ticks  = '0;
		tx_ticks  = '0;
		rx_bit    = '0;
		tx_bit    = '0;
		rx_shreg  = '0;
		tx_shreg  = '0;
		txq_rd    = 0;
		txq_wr    = 0;
		txq_count = 0;
	endtask

	// one serial tick: receiver, then transmitter, then the queue push
	task automatic predict_tick(input logic line, input logic push,
		input logic [uart_pkg::BYTE_W-1:0] data, output tick_result_t r);
		r = '0;
		r.tx_line = 1'b1;

		case (rx_phase)
			SER_IDLE: begin
				if (!line) begin
					rx_phase = SER_START;
					rx_shreg = '0;
					rx_ticks = '0;
					rx_bit   = '0;
				end
			end
			SER_START: begin
				rx_ticks = rx_ticks + 16'd1;
				rx_bit   = '0;
				if (rx_ticks >= p_cpb) begin
					rx_ticks = '0;
					rx_phase = SER_DATA;
				end
			end
			SER_DATA: begin
				rx_ticks = rx_ticks + 16'd1;
				// mid-period sample; bits past the eighth are lost
				if (rx_ticks == (p_cpb >> 1) && rx_bit < 4'd8)
					rx_shreg[rx_bit[2:0]] = line;
				if (rx_ticks >= p_cpb) begin
					rx_ticks = '0;
					rx_bit   = rx_bit + 4'd1;
				end
				if (rx_bit >= p_dbits) begin
					rx_phase   = SER_STOP;
					rx_ticks   = '0;
					r.rx_valid = 1'b1;
					r.rx_data  = rx_shreg;
					rx_shreg   = '0;
				end
			end
			default: begin
				// stop bit not checked; counter wraps if the period shrank
				rx_ticks = rx_ticks + 16'd1;
				if (rx_ticks == p_cpb) begin
					rx_ticks = '0;
					rx_phase = SER_IDLE;
				end
			end
		endcase

		case (tx_phase)
			SER_IDLE: begin
				if (txq_count > 0) begin
					tx_shreg  = txq_mem[txq_rd];
					txq_rd    = (txq_rd + 1) % uart_pkg::TX_FIFO_DEPTH;
					txq_count--;
					tx_phase  = SER_START;
					tx_ticks  = '0;
					tx_bit    = '0;
				end
			end
			SER_START: begin
				r.tx_line = 1'b0;
				tx_ticks  = tx_ticks + 16'd1;
				if (tx_ticks >= p_cpb) begin
					tx_bit   = '0;
					tx_ticks = '0;
					tx_phase = SER_DATA;
				end
			end
			SER_DATA: begin
				r.tx_line = tx_shreg[0];
				tx_ticks  = tx_ticks + 16'd1;
				if (tx_ticks >= p_cpb) begin
					tx_ticks = '0;
					tx_bit   = tx_bit + 4'd1;
					tx_shreg = tx_shreg >> 1;
				end
				if (tx_bit >= p_dbits) begin
					tx_phase = SER_STOP;
					tx_ticks = '0;
				end
			end
			default: begin
				tx_ticks = tx_ticks + 16'd1;
				if (tx_ticks == p_cpb) begin
					tx_ticks = '0;
					tx_phase = SER_IDLE;
				end
			end
		endcase

		if (push) begin
			if (txq_count >= uart_pkg::TX_FIFO_DEPTH) begin
				r.dropped = 1'b1;
			end else begin
				txq_mem[txq_wr] = data;
				txq_wr = (txq_wr + 1) % uart_pkg::TX_FIFO_DEPTH;
				txq_count++;
			end
		end
		r.level = txq_count[LVL_W-1:0];
	endtask

	// follow config writes and accepted transactions
	always @(posedge clk) begin
		tick_result_t r;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					uart_pkg::CFG_CLOCKS_PER_BIT: p_cpb = cfg_wdata;
					uart_pkg::CFG_DATA_BITS:
						p_dbits = cfg_wdata[uart_pkg::DBITS_W-1:0];
				endcase
			end
			if (in_valid && in_ready) begin
				predict_tick(rx_line, tx_push_valid, tx_push_byte, r);
				pending_results.push_back(row_typed ? row_res : r);
			end
		end
	end

	// compare each result transaction with the oldest prediction
	always @(posedge clk) begin
		tick_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result transaction with no prediction waiting");
			end else begin
				want = pending_results.pop_front();
				check_field("tx_line", 16'(tx_line), 16'(want.tx_line));
				check_field("rx_byte_valid", 16'(rx_byte_valid), 16'(want.rx_valid));
				check_field("rx_byte", 16'(rx_byte), 16'(want.rx_data));
				check_field("tx_push_dropped", 16'(tx_push_dropped), 16'(want.dropped));
				check_field("tx_queue_level", 16'(tx_queue_level), 16'(want.level));
			end
		end
	end

	// receiver side: stall patterns, plus a long hold-off on request
	initial begin
		int mode;
		int len;
		out_ready <= 1'b0;
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_TICKS) @(posedge clk);
				hold_req = 0;
			end else begin
				mode = $urandom_range(0, 3);
				len  = $urandom_range(1, 60);
				for (int i = 0; i < len; i++) begin
					case (mode)
						0: out_ready <= 1'b1;
						1: out_ready <= 1'($urandom_range(0, 1));
						2: out_ready <= (i % 4 == 0);
						default: out_ready <= ($urandom_range(0, 9) != 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// offer one tick; returns at the edge that accepts it
	task automatic send_tick(input logic line, input logic push,
		input logic [uart_pkg::BYTE_W-1:0] data, input logic typed,
		input tick_result_t res);
		in_valid      <= 1'b1;
		rx_line       <= line;
		tx_push_valid <= push;
		tx_push_byte  <= data;
		row_typed     <= typed;
		row_res       <= res;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// bursts of random length with random gaps between them
	task automatic maybe_gap();
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_config(input int cpb, input int dbits);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_index <= uart_pkg::CFG_CLOCKS_PER_BIT;
		cfg_wdata <= cpb[uart_pkg::CPB_W-1:0];
		@(posedge clk);
		cfg_index <= uart_pkg::CFG_DATA_BITS;
		cfg_wdata <= dbits[uart_pkg::CPB_W-1:0];
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
		plan_w    = (cpb < 1) ? 1 : (cpb > MAX_PLAN_W) ? MAX_PLAN_W : cpb;
		plan_bits = (dbits < 1) ? 1 : dbits;
		rx_plan.delete();
	endtask

	// receive-line traffic: mostly clean frames, some noise, cut frames and idle line
	task automatic plan_rx_traffic();
		int kind;
		int n;
		kind = $urandom_range(0, 9);
		if (kind <= 6) begin
			repeat (plan_w) rx_plan.push_back(1'b0);
			for (int b = 0; b < plan_bits; b++) begin
				n = $urandom_range(0, 1);
				repeat (plan_w) rx_plan.push_back(n[0]);
			end
			repeat (plan_w + $urandom_range(0, 2 * plan_w)) rx_plan.push_back(1'b1);
		end else if (kind == 7) begin
			repeat ($urandom_range(1, 16)) rx_plan.push_back(1'($urandom_range(0, 1)));
		end else if (kind == 8) begin
			repeat (plan_w) rx_plan.push_back(1'b0);
			repeat ($urandom_range(1, 3 * plan_w))
				rx_plan.push_back(1'($urandom_range(0, 1)));
		end else begin
			repeat ($urandom_range(1, 4 * plan_w)) rx_plan.push_back(1'b1);
		end
	endtask

	task automatic run_ticks(input int n, input int push_pct);
		logic line;
		for (int i = 0; i < n; i++) begin
			maybe_gap();
			if (rx_plan.size() == 0) plan_rx_traffic();
			line = rx_plan.pop_front();
			send_tick(line, ($urandom_range(0, 99) < push_pct),
				uart_pkg::BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
		end
	endtask

	task automatic run_phase(input int cpb, input int dbits, input int n,
		input int push_pct);
		set_config(cpb, dbits);
		run_ticks(n, push_pct);
	endtask

	task automatic add_row(input logic line, input logic push, input int data,
		input logic typed, input logic txl, input int lvl, input logic drop);
		table_row_t row;
		row.line        = line;
		row.push        = push;
		row.data        = data[uart_pkg::BYTE_W-1:0];
		row.typed       = typed;
		row.res         = '0;
		row.res.tx_line = txl;
		row.res.dropped = drop;
		row.res.level   = lvl[LVL_W-1:0];
		dir_rows.push_back(row);
	endtask

	// stop the run if it hangs
	initial begin
		#12_000_000;
		$display("tb NOT OK");
		$finish;
	end

	initial begin
		int cpb;
		int dbits;
		table_row_t row;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_index     <= uart_pkg::CFG_CLOCKS_PER_BIT;
		cfg_wdata     <= '0;
		in_valid      <= 1'b0;
		rx_line       <= 1'b1;
		tx_push_valid <= 1'b0;
		tx_push_byte  <= '0;
		row_typed     <= 1'b0;
		row_res       <= '0;
		reset_predictor();

		// reset settings: the first byte is popped into the transmitter, then the queue fills up
		add_row(1'b1, 1'b1, 8'hFF, 1'b1, 1'b1, 1, 1'b0);
		add_row(1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 1, 1'b0);
		add_row(1'b1, 1'b1, 8'hA5, 1'b1, 1'b0, 2, 1'b0);
		for (int i = 3; i <= uart_pkg::TX_FIFO_DEPTH; i++)
			add_row(1'b1, 1'b1, $urandom_range(0, 255), 1'b1, 1'b0, i, 1'b0);
		// full queue: pushes are dropped while the start bit is still out
		add_row(1'b1, 1'b1, 8'h5A, 1'b1, 1'b0, uart_pkg::TX_FIFO_DEPTH, 1'b1);
		add_row(1'b0, 1'b0, 8'h00, 1'b1, 1'b0, uart_pkg::TX_FIFO_DEPTH, 1'b0);
		add_row(1'b1, 1'b1, 8'hFF, 1'b1, 1'b0, uart_pkg::TX_FIFO_DEPTH, 1'b1);
		add_row(1'b0, 1'b0, 8'h00, 1'b0, 1'b0, 0, 1'b0);
		add_row(1'b1, 1'b1, 8'h80, 1'b0, 1'b0, 0, 1'b0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			maybe_gap();
			send_tick(row.line, row.push, row.data, row.typed, row.res);
		end

		// short period, full characters; receiver holds off at the start
		hold_req = 1;
		run_phase(2, 8, 250, 30);
		// longest period: the queue fills up
		run_phase(65535, 1, 150, 60);
		// period lowered while both engines sit in a start bit
		run_phase(4, 1, 250, 10);
		hold_req = 1;
		run_phase(3, 15, 250, 90);
		// zero data bits, then a one-tick period
		run_phase(5, 0, 200, 40);
		run_phase(1, 8, 150, 40);
		// random settings
		for (int p = 0; p < 5; p++) begin
			cpb = ($urandom_range(0, 9) < 8) ? $urandom_range(2, 12) : $urandom_range(13, 24);
			if ($urandom_range(0, 9) == 0) cpb = 1;
			dbits = ($urandom_range(0, 4) != 0) ? $urandom_range(1, 8) : $urandom_range(0, 15);
			if (p == 2) hold_req = 1;
			run_phase(cpb, dbits, 90, ($urandom_range(0, 2) == 0) ? 90 : $urandom_range(5, 40));
		end
		// zero period last: stop counters run up and never match
		run_phase(0, 4, 120, 40);

		wait_drained();
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/uart_pkg.sv
rtl/uart_ram.sv
rtl/uart_fifo.sv
rtl/uart_rx.sv
rtl/uart_tx.sv
rtl/uart_transceiver.sv
tb/sv/tb.sv
